[rtl/sync_hunt_crc8_packet_deframer_macros.svh]
// Assertion helpers shared by the deframer RTL.
`ifndef SYNC_HUNT_CRC8_PACKET_DEFRAMER_MACROS_SVH
`define SYNC_HUNT_CRC8_PACKET_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SHD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SHD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/shd_pkg.sv]
package shd_pkg;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_PKT  = 2'd1;
  localparam logic [1:0] ST_CRC_ERR = 2'd2;

  // Deframer phases
  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_BODY = 2'd1;
  localparam logic [1:0] PH_CRC  = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  // CRC-8, MSB first, zero init, no final xor
  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam int unsigned CRC_LEN = 8;

  // Beat queue between front and back
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = 2;
  localparam int unsigned Q_CNT_W = 3;

  // Register map
  localparam logic REG_SYNC = 1'b0;

  typedef struct packed {
    logic last;
    logic data;
  } beat_t;

endpackage

[rtl/shd_front.sv]
`include "sync_hunt_crc8_packet_deframer_macros.svh"

module shd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic          in_bit,
  input  logic          in_last,
  output logic          q_valid,
  output shd_pkg::beat_t q_beat,
  input  logic          q_pop
);

  shd_pkg::beat_t                       mem_r [shd_pkg::Q_DEPTH];
  logic [shd_pkg::Q_PTR_W-1:0]          wr_ptr_r, wr_ptr_nxt;
  logic [shd_pkg::Q_PTR_W-1:0]          rd_ptr_r, rd_ptr_nxt;
  logic [shd_pkg::Q_CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                                 push;
  logic                                 pop;

  assign in_tready = (cnt_r != shd_pkg::Q_CNT_W'(shd_pkg::Q_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign pop       = q_pop && q_valid;
  assign q_beat    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{last: in_last, data: in_bit};
    end
  end

  `SHD_ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= shd_pkg::Q_CNT_W'(shd_pkg::Q_DEPTH), "queue count above depth")
  `SHD_ASSERT_IMPL(a_ptr_gap, clk, rst_n, cnt_r != shd_pkg::Q_CNT_W'(shd_pkg::Q_DEPTH), (wr_ptr_r - rd_ptr_r) == cnt_r[shd_pkg::Q_PTR_W-1:0], "queue pointers disagree with count")
  `SHD_ASSERT_NEXT(a_push_grows, clk, rst_n, push && !pop, cnt_r == $past(cnt_r) + 1'b1, "push lost in queue")

endmodule

[rtl/shd_back.sv]
`include "sync_hunt_crc8_packet_deframer_macros.svh"

module shd_back #(
  parameter int unsigned SYNC_BITS = 16,
  parameter int unsigned ID_BITS   = 8,
  parameter int unsigned DT_BITS   = 32,
  parameter int unsigned MEAS_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [15:0]          sync_pattern,
  input  logic                 q_valid,
  input  shd_pkg::beat_t       q_beat,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic [7:0]           out_resp,
  output logic signed [31:0]   out_dt,
  output logic [15:0]          out_meas
);

  localparam int unsigned BODY_LEN = ID_BITS + DT_BITS + MEAS_BITS;
  localparam int unsigned FILL_W   = $clog2(SYNC_BITS + 1);
  localparam int unsigned CNT_MAX  = (BODY_LEN > shd_pkg::CRC_LEN) ? BODY_LEN
                                                                    : shd_pkg::CRC_LEN;
  localparam int unsigned CNT_W    = $clog2(CNT_MAX);

  logic [SYNC_BITS-1:0] win_r, win_nxt;
  logic [FILL_W-1:0]    fill_r, fill_nxt;
  logic [1:0]           phase_r, phase_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [7:0]           crc_r, crc_nxt;
  logic [BODY_LEN-1:0]  body_r, body_nxt;
  logic [7:0]           crc_rx_r, crc_rx_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           status_r, status_nxt;
  logic [7:0]           resp_r, resp_nxt;
  logic signed [31:0]   dt_r, dt_nxt;
  logic [15:0]          meas_r, meas_nxt;

  logic                 bit_in;
  logic                 fb;
  logic [DT_BITS-1:0]   dt_raw;

  // Take a beat unless it closes a buffer and the result slot is still occupied
  assign q_pop  = q_valid && (!q_beat.last || !out_valid_r || out_ready);
  assign bit_in = q_beat.data;
  assign fb     = crc_r[7] ^ bit_in;

  always_comb begin
    win_nxt       = win_r;
    fill_nxt      = fill_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    crc_nxt       = crc_r;
    body_nxt      = body_r;
    crc_rx_nxt    = crc_rx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    resp_nxt      = resp_r;
    dt_nxt        = dt_r;
    meas_nxt      = meas_r;
    dt_raw        = '0;

    if (q_pop) begin
      case (phase_r)
        shd_pkg::PH_HUNT: begin
          win_nxt = SYNC_BITS'({win_r, bit_in});
          if (fill_r != FILL_W'(SYNC_BITS)) begin
            fill_nxt = fill_r + 1'b1;
          end
          if (fill_nxt == FILL_W'(SYNC_BITS) && win_nxt == sync_pattern[SYNC_BITS-1:0]) begin
            phase_nxt = shd_pkg::PH_BODY;
            cnt_nxt   = '0;
            crc_nxt   = '0;
            body_nxt  = '0;
          end
        end
        shd_pkg::PH_BODY: begin
          body_nxt = BODY_LEN'({body_r, bit_in});
          crc_nxt  = {crc_r[6:0], 1'b0} ^ (fb ? shd_pkg::CRC_POLY : 8'h00);
          cnt_nxt  = cnt_r + 1'b1;
          if (cnt_r == CNT_W'(BODY_LEN - 1)) begin
            phase_nxt  = shd_pkg::PH_CRC;
            cnt_nxt    = '0;
            crc_rx_nxt = '0;
          end
        end
        shd_pkg::PH_CRC: begin
          crc_rx_nxt = {crc_rx_r[6:0], bit_in};
          cnt_nxt    = cnt_r + 1'b1;
          if (cnt_r == CNT_W'(shd_pkg::CRC_LEN - 1)) begin
            phase_nxt = shd_pkg::PH_DONE;
          end
        end
        default: begin
          // Drop bits after a complete packet
        end
      endcase

      if (q_beat.last) begin
        out_valid_nxt = 1'b1;
        status_nxt    = shd_pkg::ST_NO_PKT;
        resp_nxt      = '0;
        dt_nxt        = '0;
        meas_nxt      = '0;
        if (phase_nxt == shd_pkg::PH_DONE) begin
          if (crc_rx_nxt != crc_nxt) begin
            status_nxt = shd_pkg::ST_CRC_ERR;
          end else begin
            dt_raw     = body_nxt[MEAS_BITS +: DT_BITS];
            status_nxt = shd_pkg::ST_OK;
            resp_nxt   = 8'(body_nxt[DT_BITS + MEAS_BITS +: ID_BITS]);
            dt_nxt     = 32'($signed(dt_raw));
            meas_nxt   = 16'(body_nxt[MEAS_BITS-1:0]);
          end
        end
        // Clear the framing state for the next buffer
        win_nxt    = '0;
        fill_nxt   = '0;
        phase_nxt  = shd_pkg::PH_HUNT;
        cnt_nxt    = '0;
        crc_nxt    = '0;
        body_nxt   = '0;
        crc_rx_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= '0;
      fill_r      <= '0;
      phase_r     <= shd_pkg::PH_HUNT;
      cnt_r       <= '0;
      crc_r       <= '0;
      body_r      <= '0;
      crc_rx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      win_r       <= win_nxt;
      fill_r      <= fill_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      crc_r       <= crc_nxt;
      body_r      <= body_nxt;
      crc_rx_r    <= crc_rx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    resp_r   <= resp_nxt;
    dt_r     <= dt_nxt;
    meas_r   <= meas_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_resp   = resp_r;
  assign out_dt     = dt_r;
  assign out_meas   = meas_r;

  `SHD_ASSERT_IMPL(a_framed_after_fill, clk, rst_n, phase_r != shd_pkg::PH_HUNT, fill_r == FILL_W'(SYNC_BITS), "left hunt before the sync window filled")
  `SHD_ASSERT_NEXT(a_last_gives_result, clk, rst_n, q_pop && q_beat.last, out_valid_r && phase_r == shd_pkg::PH_HUNT, "buffer end without result or reset of framing")
  `SHD_ASSERT_IMPL(a_status_code, clk, rst_n, out_valid_r, status_r == shd_pkg::ST_OK || status_r == shd_pkg::ST_NO_PKT || status_r == shd_pkg::ST_CRC_ERR, "undefined status code")
  `SHD_ASSERT_IMPL(a_zero_on_fail, clk, rst_n, out_valid_r && status_r != shd_pkg::ST_OK, resp_r == '0 && dt_r == '0 && meas_r == '0, "fields not zero on failed packet")

endmodule

[rtl/sync_hunt_crc8_packet_deframer.sv]
// Serial sync-hunting packet deframer with CRC-8 (poly 0x07) check.
// Input stream: one received bit per beat in in_tdata[0]; in_tlast marks the
// final bit of a buffer. The block hunts for the first sync word (low
// SYNC_BITS of the sync register), collects the body (responder id, signed
// time difference, measurement number, MSB first) and 8 CRC bits.
// Output stream: exactly one result beat per buffer, produced for the beat
// carrying in_tlast. out_tuser carries the status (ok / no packet / CRC error),
// out_tdata the fields, zero unless the status is ok.
// Throughput: one input beat per cycle while no result waits on out_tready; a front
// queue of four beats feeds the bit engine, which consumes one beat per cycle.
// Result path: the closing beat passes through the queue and then the engine's
// result register, which drives out_tvalid.
// Stall: while a result waits on out_tready the engine keeps taking data
// beats and halts only at the next buffer end; the queue then fills and
// in_tready falls.
// Reset (rst_n low, synchronous): clears the queue, framing state, pending
// result and the sync register (to zero).
// Config: sync register at byte address 0; write it only while idle (the block does not enforce this).
module sync_hunt_crc8_packet_deframer #(
  parameter int unsigned SYNC_BITS = 16,
  parameter int unsigned ID_BITS   = 8,
  parameter int unsigned DT_BITS   = 32,
  parameter int unsigned MEAS_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] data_bit, [7:1] zero fill
  input  logic        in_tlast,   // last_bit
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [7:0] responder_number, [39:8] time_difference,
                                  // [55:40] measurement_index
  output logic [1:0]  out_tuser,  // [1:0] status
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0]          sync_r, sync_nxt;
  logic                 cfg_wr;
  logic                 q_valid;
  logic                 q_pop;
  shd_pkg::beat_t       q_beat;
  logic [7:0]           resp;
  logic signed [31:0]   dt;
  logic [15:0]          meas;

  // Register write on the APB access phase; register index is paddr[2]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == shd_pkg::REG_SYNC);

  always_comb begin
    sync_nxt = cfg_wr ? pwdata[15:0] : sync_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= '0;
    end else begin
      sync_r <= sync_nxt;
    end
  end

  assign prdata = (paddr[2] == shd_pkg::REG_SYNC) ? {16'h0000, sync_r} : 32'h0;

  // Front: accept and queue beats
  shd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_bit    (in_tdata[0]),
    .in_last   (in_tlast),
    .q_valid   (q_valid),
    .q_beat    (q_beat),
    .q_pop     (q_pop)
  );

  // Back: hunt, collect body, check CRC, hold result
  shd_back #(
    .SYNC_BITS (SYNC_BITS),
    .ID_BITS   (ID_BITS),
    .DT_BITS   (DT_BITS),
    .MEAS_BITS (MEAS_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .sync_pattern (sync_r),
    .q_valid      (q_valid),
    .q_beat       (q_beat),
    .q_pop        (q_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_status   (out_tuser),
    .out_resp     (resp),
    .out_dt       (dt),
    .out_meas     (meas)
  );

  assign out_tdata = {meas, dt, resp};

endmodule

[dv/sync_hunt_crc8_packet_deframer_tb.sv]
module sync_hunt_crc8_packet_deframer_tb;

  localparam int SYNC_LEN    = 16;
  localparam int BODY_LEN    = 56;
  localparam int CRC8_LEN    = 8;
  localparam logic [7:0] CRC8_POLY = 8'h07;
  localparam logic [2:0] SYNC_REG_ADDR = {shd_pkg::REG_SYNC, 2'b00};
  // Covers the result register and the four-beat front queue, with margin.
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 200000;

  typedef enum logic [1:0] {TRK_HUNT, TRK_BODY, TRK_CRC, TRK_DONE} track_phase_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [7:0]         responder;
    logic signed [31:0] tdiff;
    logic [15:0]        meas;
  } readout_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [0] data bit, [7:1] zero fill
  logic        in_tlast;   // last bit of the buffer
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;  // [7:0] responder, [39:8] time difference, [55:40] measurement
  logic [1:0]  out_tuser;  // [1:0] status
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  sync_hunt_crc8_packet_deframer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Shadow of the deframer: sync register and framing state.
  logic [15:0]  sync_word;
  logic [15:0]  hunt_window;
  int           hunt_fill;
  track_phase_t trk_phase;
  int           bit_cnt;
  logic [7:0]   crc_acc;
  logic [55:0]  body_bits;
  logic [7:0]   crc_rx;

  readout_t decoded_q[$];   // decoded results still owed by the block
  logic     frame_q[$];     // bits of the buffer being built

  bit tx_gaps = 1'b1;
  bit rx_gaps = 1'b1;
  int rx_hold_left = 0;
  int fresh_bits = 0;       // bits not ignored by the block
  int buffers_sent = 0;
  int errors = 0;
  int cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort on a hung handshake.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL sync_hunt_crc8_packet_deframer");
      $finish;
    end
  end

  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic b);
    logic fb;
    fb = crc[7] ^ b;
    crc = {crc[6:0], 1'b0};
    if (fb) crc = crc ^ CRC8_POLY;
    return crc;
  endfunction

  task automatic tracker_clear();
    hunt_window = '0;
    hunt_fill   = 0;
    trk_phase   = TRK_HUNT;
    bit_cnt     = 0;
    crc_acc     = '0;
    body_bits   = '0;
    crc_rx      = '0;
  endtask

  // Advance the shadow framer by one accepted beat; queue a result on the last bit.
  task automatic track_beat(input logic b, input logic l);
    readout_t r;
    if (trk_phase != TRK_DONE) fresh_bits++;
    case (trk_phase)
      TRK_HUNT: begin
        hunt_window = {hunt_window[14:0], b};
        if (hunt_fill < SYNC_LEN) hunt_fill++;
        // A match only counts once the window holds a full sync's worth of this buffer.
        if (hunt_fill == SYNC_LEN && hunt_window == sync_word) begin
          trk_phase = TRK_BODY;
          bit_cnt   = 0;
          crc_acc   = '0;
          body_bits = '0;
        end
      end
      TRK_BODY: begin
        crc_acc   = crc8_next(crc_acc, b);
        body_bits = {body_bits[54:0], b};
        bit_cnt++;
        if (bit_cnt == BODY_LEN) begin
          trk_phase = TRK_CRC;
          bit_cnt   = 0;
          crc_rx    = '0;
        end
      end
      TRK_CRC: begin
        crc_rx = {crc_rx[6:0], b};
        bit_cnt++;
        if (bit_cnt == CRC8_LEN) trk_phase = TRK_DONE;
      end
      default: ;  // drop bits after a complete packet
    endcase
    if (l) begin
      r = '{status: shd_pkg::ST_NO_PKT, responder: '0, tdiff: '0, meas: '0};
      if (trk_phase == TRK_DONE) begin
        if (crc_rx != crc_acc) begin
          r.status = shd_pkg::ST_CRC_ERR;
        end else begin
          r.status    = shd_pkg::ST_OK;
          r.responder = body_bits[55:48];
          r.tdiff     = body_bits[47:16];
          r.meas      = body_bits[15:0];
        end
      end
      decoded_q.insert(decoded_q.size(), r);
      buffers_sent++;
      tracker_clear();
    end
  endtask

  // Offer one beat, with random gaps ahead of it; track it once accepted.
  task automatic send_beat(input logic b, input logic l);
    @(negedge clk);
    while (tx_gaps && $urandom_range(99) < 37) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, b};
    in_tlast  <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    track_beat(b, l);
  endtask

  task automatic hold_sender();
    @(negedge clk);
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
  endtask

  task automatic send_frame();
    int n;
    n = frame_q.size();
    for (int i = 0; i < n; i++) send_beat(frame_q[i], i == n - 1);
    frame_q.delete();
  endtask

  // Wait until every result is back and the engine has run dry.
  task automatic drain();
    hold_sender();
    while (decoded_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == SYNC_REG_ADDR) sync_word = data[15:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic push_bits(input logic [63:0] value, input int n);
    for (int i = n - 1; i >= 0; i--) frame_q.insert(frame_q.size(), value[i]);
  endtask

  task automatic push_noise(input int n);
    for (int i = 0; i < n; i++) frame_q.insert(frame_q.size(), logic'($urandom_range(1)));
  endtask

  // Append sync, body and CRC; keep only the first `keep` bits after the sync,
  // then add `trail` junk bits if the packet is whole.
  task automatic push_packet(input logic [15:0] sync, input logic [55:0] body,
                             input logic [7:0] crc_flip, input int keep, input int trail);
    logic [7:0]  crc;
    logic [63:0] tail;
    crc = '0;
    for (int i = BODY_LEN - 1; i >= 0; i--) crc = crc8_next(crc, body[i]);
    tail = {body, crc ^ crc_flip};
    push_bits(64'(sync), SYNC_LEN);
    for (int i = 63; i >= 64 - keep; i--) frame_q.insert(frame_q.size(), tail[i]);
    if (keep == 64) push_noise(trail);
  endtask

  function automatic logic [55:0] random_body();
    logic [7:0]  id;
    logic [31:0] dt;
    logic [15:0] ms;
    case ($urandom_range(3))
      0:       id = 8'h00;
      1:       id = 8'hff;
      default: id = 8'($urandom);
    endcase
    case ($urandom_range(7))
      0:       dt = 32'h8000_0000;
      1:       dt = 32'h7fff_ffff;
      2:       dt = 32'hffff_ffff;
      3:       dt = 32'h0000_0000;
      default: dt = $urandom;
    endcase
    case ($urandom_range(3))
      0:       ms = 16'h0000;
      1:       ms = 16'hffff;
      default: ms = 16'($urandom);
    endcase
    return {id, dt, ms};
  endfunction

  // Sync word with junk in the upper half, which the block must ignore.
  function automatic logic [31:0] pick_sync_setting();
    logic [15:0] pat;
    case ($urandom_range(5))
      0:       pat = 16'h0000;
      1:       pat = 16'hffff;
      default: pat = 16'($urandom);
    endcase
    return {16'($urandom), pat};
  endfunction

  // Mostly well-formed packets with random content; the rest broken or noise.
  task automatic build_random_buffer();
    int kind;
    kind = $urandom_range(99);
    if (kind >= 84) begin
      push_noise($urandom_range(1, 40));
    end else begin
      push_noise($urandom_range(0, 24));
      push_packet(sync_word, random_body(),
                  (kind >= 60 && kind < 72) ? 8'($urandom_range(1, 255)) : 8'h00,
                  (kind >= 72) ? $urandom_range(0, 63) : 64,
                  $urandom_range(0, 6));
    end
  endtask

  // Reset value of the sync word is zero; cover short buffers and the window fill.
  task automatic test_short_buffers();
    push_bits(64'h1, 1);                 // lone bit
    send_frame();
    push_bits(64'h0, 15);                // zeros, but window never fills
    send_frame();
    push_bits(64'h0, 16);                // ends on the sync's own last bit
    send_frame();
    push_packet(16'h0000, {8'h3c, 32'h1234_5678, 16'h9abc}, 8'h00, 64, 0);
    send_frame();
  endtask

  task automatic test_field_extremes();
    drain();
    apb_write(SYNC_REG_ADDR, 32'h0000_ffff);
    push_packet(16'hffff, {8'hff, 32'h7fff_ffff, 16'hffff}, 8'h00, 64, 0);
    send_frame();
    push_packet(16'hffff, {8'h00, 32'h8000_0000, 16'h0000}, 8'h00, 64, 3);
    send_frame();
    push_packet(16'hffff, {8'ha5, 32'hffff_ffff, 16'h1234}, 8'h00, 64, 1);
    send_frame();
  endtask

  task automatic test_crc_error();
    push_packet(sync_word, random_body(), 8'h01, 64, 0);
    send_frame();
    push_packet(sync_word, random_body(), 8'h80, 64, 2);
    send_frame();
  endtask

  task automatic test_truncated();
    push_packet(sync_word, random_body(), 8'h00, 20, 0);   // ends inside the body
    send_frame();
    push_packet(sync_word, random_body(), 8'h00, 60, 0);   // ends inside the CRC
    send_frame();
    push_packet(sync_word, random_body(), 8'h00, 63, 0);   // one CRC bit short
    send_frame();
  endtask

  // A second sync after a complete packet must be ignored.
  task automatic test_trailing_bits();
    push_packet(sync_word, random_body(), 8'h00, 64, 0);
    push_bits(64'(sync_word), SYNC_LEN);
    push_bits(64'h00ba_df00, 24);
    send_frame();
  endtask

  task automatic test_no_sync();
    drain();
    apb_write(SYNC_REG_ADDR, 32'hdead_ffff);
    push_bits(64'h5555_5555_55, 40);     // alternating bits never form sixteen ones
    send_frame();
    push_noise(20);
    push_packet(sync_word, random_body(), 8'h00, 64, 0);
    send_frame();
  endtask

  // Change the sync word while a buffer is half received.
  task automatic test_midbuffer_config();
    drain();
    apb_write(SYNC_REG_ADDR, 32'h0000_1234);
    for (int i = 0; i < 10; i++) send_beat(logic'($urandom_range(1)), 1'b0);
    drain();
    apb_write(SYNC_REG_ADDR, 32'h5a5a_beef);
    push_packet(16'hbeef, random_body(), 8'h00, 64, 0);
    send_frame();
  endtask

  // Hold the result side off so the queue fills and the input stalls.
  task automatic test_backpressure();
    tx_gaps = 1'b0;
    rx_hold_left = 400;
    for (int i = 0; i < 16; i++) begin
      push_noise(2);
      send_frame();
    end
    push_packet(sync_word, random_body(), 8'h00, 64, 0);
    send_frame();
    tx_gaps = 1'b1;
  endtask

  task automatic test_random_traffic(input int bit_goal, input int buffer_goal);
    int bits0;
    int bufs0;
    int n;
    bits0 = fresh_bits;
    bufs0 = buffers_sent;
    n = 0;
    while (fresh_bits - bits0 < bit_goal || buffers_sent - bufs0 < buffer_goal) begin
      if (n % 3 == 2) begin
        drain();
        apb_write(SYNC_REG_ADDR, pick_sync_setting());
      end
      build_random_buffer();
      send_frame();
      n++;
    end
  endtask

  // Drive the result-side ready; a requested hold-off is counted down here.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(rx_gaps && $urandom_range(99) < 37);
      end
    end
  end

  // Compare each result beat with the oldest decoded result.
  always @(posedge clk) begin : check_results
    readout_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected result beat: status %0d tdata %h", out_tuser, out_tdata);
        errors++;
      end else begin
        want = decoded_q.pop_front();
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tuser);
          errors++;
        end
        if (out_tdata[7:0] !== want.responder) begin
          $error("responder_number: expected %0d, got %0d", want.responder, out_tdata[7:0]);
          errors++;
        end
        if (out_tdata[39:8] !== want.tdiff) begin
          $error("time_difference: expected %0d, got %0d",
                 want.tdiff, $signed(out_tdata[39:8]));
          errors++;
        end
        if (out_tdata[55:40] !== want.meas) begin
          $error("measurement_index: expected %0d, got %0d", want.meas, out_tdata[55:40]);
          errors++;
        end
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    sync_word = '0;
    tracker_clear();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    test_short_buffers();
    test_field_extremes();
    test_crc_error();
    test_truncated();
    test_trailing_bits();
    test_no_sync();
    test_midbuffer_config();
    test_backpressure();

    // Full-rate stretch on both sides, then random gaps again.
    drain();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    test_random_traffic(120, 2);
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    test_random_traffic(220, 2);

    drain();
    if (errors == 0) begin
      $display("PASS sync_hunt_crc8_packet_deframer");
    end else begin
      $display("FAIL sync_hunt_crc8_packet_deframer");
    end
    $finish;
  end

endmodule
